FILE: rtl/sse_pkg.sv
package sse_pkg;

   // Result kinds carried in the kind field of a response word.
   localparam logic [2:0] KIND_DATA_START = 3'd0;
   localparam logic [2:0] KIND_DATA_BYTE  = 3'd1;
   localparam logic [2:0] KIND_NAME_START = 3'd2;
   localparam logic [2:0] KIND_NAME_BYTE  = 3'd3;
   localparam logic [2:0] KIND_DONE       = 3'd4;
   localparam logic [2:0] KIND_ERROR      = 3'd5;

   // Input modes.
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_EOS  = 1'b1;

   // Line phases.
   localparam logic [1:0] PHASE_FIELD   = 2'd0;
   localparam logic [1:0] PHASE_VALUE   = 2'd1;
   localparam logic [1:0] PHASE_COMMENT = 2'd2;

   // Field classification while the field name is being scanned.
   localparam logic [1:0] FIELD_NONE  = 2'd0;
   localparam logic [1:0] FIELD_DATA  = 2'd1;
   localparam logic [1:0] FIELD_EVENT = 2'd2;
   localparam logic [1:0] FIELD_OTHER = 2'd3;

   // Characters of interest.
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Field name lengths.
   localparam logic [2:0] DATA_LEN  = 3'd4;
   localparam logic [2:0] EVENT_LEN = 3'd5;

   localparam logic [31:0] LIMIT_RESET = 32'd1048576;

   typedef struct packed {
      logic       mode;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] out_byte;
      logic       with_separator;
      logic       name_empty;
      logic       last;
   } rsp_type;

   // Letters of the "data" field name.
   function automatic logic [7:0] data_char(input logic [1:0] idx);
      logic [7:0] c;
      unique case (idx)
         2'd0: c = 8'h64;
         2'd1: c = 8'h61;
         2'd2: c = 8'h74;
         2'd3: c = 8'h61;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Letters of the "event" field name.
   function automatic logic [7:0] event_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0: c = 8'h65;
         3'd1: c = 8'h76;
         3'd2: c = 8'h65;
         3'd3: c = 8'h6E;
         3'd4: c = 8'h74;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/sse_event_stream_parser.sv
// Server-Sent Events stream parser. One stream byte or end-of-stream mark is
// taken per cycle on the req_ channel and turned into token words on the rsp_
// channel (data line start, data byte, name start, name byte, event done, size
// error). An accepted word is registered, then parsed against the
// line state and the byte counter, and its zero, one or two result words go
// into a four-entry output queue. Input is taken every cycle as long as the
// queue holds no more than two words; an end-of-stream mark can yield two
// result words, which leave at one word per cycle while rsp_ready is high. The
// event size limit is written through csr_write_en and csr_write_data by the
// user only while the block is idle; the block itself does not enforce it.
module sse_event_stream_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sse_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sse_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [31:0]      csr_write_data
);

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);

   // Configuration register.
   logic [31:0] limit_ff;

   // Input register.
   logic             in_valid_ff;
   sse_pkg::req_type in_ff;

   // Parser state.
   logic [1:0]  line_phase_ff, line_phase_in;
   logic [2:0]  field_match_ff, field_match_in;
   logic [1:0]  field_kind_ff, field_kind_in;
   logic        value_started_ff, value_started_in;
   logic        line_nonempty_ff, line_nonempty_in;
   logic        after_cr_ff, after_cr_in;
   logic        has_data_ff, has_data_in;
   logic        name_nonempty_ff, name_nonempty_in;
   logic [31:0] byte_count_ff, byte_count_in;
   logic        error_ff, error_in;

   // Output queue.
   sse_pkg::rsp_type     fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]     head_ff, tail_ff;
   logic [PTR_W:0]       count_ff;

   sse_pkg::rsp_type res [2];
   logic [1:0]       res_cnt;
   logic             process;
   logic             pop;
   logic             over_limit;
   logic [7:0]       b;

   // The input stage advances when the queue has room for two words.
   assign process   = in_valid_ff && (count_ff <= (PTR_W+1)'(2));
   assign req_ready = !in_valid_ff || process;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = fifo_ff[head_ff];

   assign b          = in_ff.byte_value;
   assign over_limit = (byte_count_ff >= limit_ff);

   // Parse one registered input word against the line state.
   always_comb begin
      line_phase_in    = line_phase_ff;
      field_match_in   = field_match_ff;
      field_kind_in    = field_kind_ff;
      value_started_in = value_started_ff;
      line_nonempty_in = line_nonempty_ff;
      after_cr_in      = after_cr_ff;
      has_data_in      = has_data_ff;
      name_nonempty_in = name_nonempty_ff;
      byte_count_in    = byte_count_ff;
      error_in         = error_ff;
      res[0]           = '0;
      res[1]           = '0;
      res_cnt          = 2'd0;

      if (error_ff) begin
         res[0].kind = sse_pkg::KIND_ERROR;
         res_cnt     = 2'd1;
      end else if (in_ff.mode == sse_pkg::MODE_EOS) begin
         after_cr_in = 1'b0;
         if (line_nonempty_ff && over_limit) begin
            error_in    = 1'b1;
            res[0].kind = sse_pkg::KIND_ERROR;
            res_cnt     = 2'd1;
         end else begin
            // Close an open line first.
            if (line_nonempty_ff && line_phase_ff == sse_pkg::PHASE_FIELD) begin
               if (field_kind_ff == sse_pkg::FIELD_DATA &&
                   field_match_ff == sse_pkg::DATA_LEN) begin
                  res[0].kind           = sse_pkg::KIND_DATA_START;
                  res[0].with_separator = has_data_ff;
                  res_cnt               = 2'd1;
                  has_data_in           = 1'b1;
               end else if (field_kind_ff == sse_pkg::FIELD_EVENT &&
                            field_match_ff == sse_pkg::EVENT_LEN) begin
                  res[0].kind      = sse_pkg::KIND_NAME_START;
                  res_cnt          = 2'd1;
                  name_nonempty_in = 1'b0;
               end
            end
            line_phase_in    = sse_pkg::PHASE_FIELD;
            field_match_in   = '0;
            field_kind_in    = sse_pkg::FIELD_NONE;
            value_started_in = 1'b0;
            line_nonempty_in = 1'b0;
            // Then dispatch the event.
            if (has_data_in) begin
               res[res_cnt[0]].kind       = sse_pkg::KIND_DONE;
               res[res_cnt[0]].name_empty = !name_nonempty_in;
               res_cnt                    = res_cnt + 2'd1;
            end
            has_data_in      = 1'b0;
            name_nonempty_in = 1'b0;
            byte_count_in    = '0;
         end
      end else if (after_cr_ff && b == sse_pkg::CHAR_LF) begin
         // Second half of a CRLF pair: dropped and not counted.
         after_cr_in = 1'b0;
      end else begin
         after_cr_in = 1'b0;
         if (over_limit) begin
            error_in    = 1'b1;
            res[0].kind = sse_pkg::KIND_ERROR;
            res_cnt     = 2'd1;
         end else begin
            byte_count_in = byte_count_ff + 32'd1;
            if (b == sse_pkg::CHAR_CR || b == sse_pkg::CHAR_LF) begin
               after_cr_in = (b == sse_pkg::CHAR_CR);
               if (line_nonempty_ff) begin
                  if (line_phase_ff == sse_pkg::PHASE_FIELD) begin
                     if (field_kind_ff == sse_pkg::FIELD_DATA &&
                         field_match_ff == sse_pkg::DATA_LEN) begin
                        res[0].kind           = sse_pkg::KIND_DATA_START;
                        res[0].with_separator = has_data_ff;
                        res_cnt               = 2'd1;
                        has_data_in           = 1'b1;
                     end else if (field_kind_ff == sse_pkg::FIELD_EVENT &&
                                  field_match_ff == sse_pkg::EVENT_LEN) begin
                        res[0].kind      = sse_pkg::KIND_NAME_START;
                        res_cnt          = 2'd1;
                        name_nonempty_in = 1'b0;
                     end
                  end
                  line_phase_in    = sse_pkg::PHASE_FIELD;
                  field_match_in   = '0;
                  field_kind_in    = sse_pkg::FIELD_NONE;
                  value_started_in = 1'b0;
                  line_nonempty_in = 1'b0;
               end else begin
                  // Empty line dispatches the event.
                  if (has_data_ff) begin
                     res[0].kind       = sse_pkg::KIND_DONE;
                     res[0].name_empty = !name_nonempty_ff;
                     res_cnt           = 2'd1;
                  end
                  has_data_in      = 1'b0;
                  name_nonempty_in = 1'b0;
                  byte_count_in    = '0;
               end
            end else if (line_phase_ff == sse_pkg::PHASE_FIELD) begin
               line_nonempty_in = 1'b1;
               if (b == sse_pkg::CHAR_COLON) begin
                  line_phase_in = sse_pkg::PHASE_VALUE;
                  if (!line_nonempty_ff) begin
                     line_phase_in = sse_pkg::PHASE_COMMENT;
                  end else if (field_kind_ff == sse_pkg::FIELD_DATA &&
                               field_match_ff == sse_pkg::DATA_LEN) begin
                     res[0].kind           = sse_pkg::KIND_DATA_START;
                     res[0].with_separator = has_data_ff;
                     res_cnt               = 2'd1;
                     has_data_in           = 1'b1;
                  end else if (field_kind_ff == sse_pkg::FIELD_EVENT &&
                               field_match_ff == sse_pkg::EVENT_LEN) begin
                     res[0].kind      = sse_pkg::KIND_NAME_START;
                     res_cnt          = 2'd1;
                     name_nonempty_in = 1'b0;
                  end else begin
                     field_kind_in = sse_pkg::FIELD_OTHER;
                  end
               end else begin
                  // Match the field name one letter at a time.
                  unique case (field_kind_ff)
                     sse_pkg::FIELD_NONE: begin
                        if (b == sse_pkg::data_char(2'd0)) begin
                           field_kind_in  = sse_pkg::FIELD_DATA;
                           field_match_in = 3'd1;
                        end else if (b == sse_pkg::event_char(3'd0)) begin
                           field_kind_in  = sse_pkg::FIELD_EVENT;
                           field_match_in = 3'd1;
                        end else begin
                           field_kind_in = sse_pkg::FIELD_OTHER;
                        end
                     end
                     sse_pkg::FIELD_DATA: begin
                        if (field_match_ff < sse_pkg::DATA_LEN &&
                            b == sse_pkg::data_char(field_match_ff[1:0])) begin
                           field_match_in = field_match_ff + 3'd1;
                        end else begin
                           field_kind_in = sse_pkg::FIELD_OTHER;
                        end
                     end
                     sse_pkg::FIELD_EVENT: begin
                        if (field_match_ff < sse_pkg::EVENT_LEN &&
                            b == sse_pkg::event_char(field_match_ff)) begin
                           field_match_in = field_match_ff + 3'd1;
                        end else begin
                           field_kind_in = sse_pkg::FIELD_OTHER;
                        end
                     end
                     default: begin
                        field_kind_in = field_kind_ff;
                     end
                  endcase
               end
            end else if (line_phase_ff == sse_pkg::PHASE_VALUE) begin
               // One leading space of the value is dropped.
               value_started_in = 1'b1;
               if (value_started_ff || b != sse_pkg::CHAR_SPACE) begin
                  if (field_kind_ff == sse_pkg::FIELD_DATA) begin
                     res[0].kind     = sse_pkg::KIND_DATA_BYTE;
                     res[0].out_byte = b;
                     res_cnt         = 2'd1;
                  end else if (field_kind_ff == sse_pkg::FIELD_EVENT) begin
                     res[0].kind      = sse_pkg::KIND_NAME_BYTE;
                     res[0].out_byte  = b;
                     res_cnt          = 2'd1;
                     name_nonempty_in = 1'b1;
                  end
               end
            end
         end
      end

      // Mark the final word of this item.
      if (res_cnt == 2'd2) begin
         res[1].last = 1'b1;
      end else if (res_cnt == 2'd1) begin
         res[0].last = 1'b1;
      end
   end

   // Configuration and input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= sse_pkg::LIMIT_RESET;
         in_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            limit_ff <= csr_write_data;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   // Parser state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_phase_ff    <= sse_pkg::PHASE_FIELD;
         field_match_ff   <= '0;
         field_kind_ff    <= sse_pkg::FIELD_NONE;
         value_started_ff <= 1'b0;
         line_nonempty_ff <= 1'b0;
         after_cr_ff      <= 1'b0;
         has_data_ff      <= 1'b0;
         name_nonempty_ff <= 1'b0;
         byte_count_ff    <= '0;
         error_ff         <= 1'b0;
      end else if (process) begin
         line_phase_ff    <= line_phase_in;
         field_match_ff   <= field_match_in;
         field_kind_ff    <= field_kind_in;
         value_started_ff <= value_started_in;
         line_nonempty_ff <= line_nonempty_in;
         after_cr_ff      <= after_cr_in;
         has_data_ff      <= has_data_in;
         name_nonempty_ff <= name_nonempty_in;
         byte_count_ff    <= byte_count_in;
         error_ff         <= error_in;
      end
   end

   // Output queue pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (pop) begin
            head_ff <= head_ff + PTR_W'(1);
         end
         if (process) begin
            tail_ff <= tail_ff + PTR_W'(res_cnt);
         end
         count_ff <= count_ff + (process ? (PTR_W+1)'(res_cnt) : '0)
                     - (PTR_W+1)'(pop);
      end
   end

   // Output queue storage.
   always_ff @(posedge clock) begin
      if (process && res_cnt != 2'd0) begin
         fifo_ff[tail_ff] <= res[0];
      end
      if (process && res_cnt == 2'd2) begin
         fifo_ff[tail_ff + PTR_W'(1)] <= res[1];
      end
   end

endmodule

FILE: rtl/sse_checker.sv
module sse_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input sse_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sse_pkg::rsp_type rsp_data
);

   // A stalled request word holds.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request word changed while stalled");

   // A stalled response word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // The output queue is empty right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Event done always closes the words of its item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == sse_pkg::KIND_DONE |-> rsp_data.last)
      else $error("event done not marked last");

   // Once an error is reported, every later word is an error.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.kind == sse_pkg::KIND_ERROR |=>
         !rsp_valid || rsp_data.kind == sse_pkg::KIND_ERROR)
      else $error("error flag not sticky");

endmodule

bind sse_event_stream_parser sse_checker u_sse_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: tb/sse_event_stream_parser_tb.sv
`timescale 1ns / 1ps

module sse_event_stream_parser_tb;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 12;
   localparam logic [31:0] WIDE_LIMIT   = 32'hFFFF_FFFF;
   localparam logic [31:0] FIT_LIMIT    = 32'd12;
   localparam logic [31:0] ZERO_LIMIT   = 32'd0;
   localparam logic [31:0] OPEN_LIMIT   = 32'd5000;

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             req_valid      = 1'b0;
   logic             req_ready;
   sse_pkg::req_type req_data       = '0;
   logic             rsp_valid;
   logic             rsp_ready      = 1'b0;
   sse_pkg::rsp_type rsp_data;
   logic             csr_write_en   = 1'b0;
   logic [31:0]      csr_write_data = '0;

   // Words waiting to be sent, and tokens the parser still owes us.
   sse_pkg::req_type pending_words[$];
   sse_pkg::rsp_type expected_tokens[$];
   sse_pkg::rsp_type step_tokens[$];
   int unsigned words_queued = 0;
   int unsigned failures     = 0;
   int unsigned cycle_count  = 0;
   int unsigned send_gap     = 0;
   int unsigned take_gap     = 0;
   bit          send_steady  = 1'b0;
   bit          take_steady  = 1'b0;

   // Shadow copy of the parser state and the size limit.
   logic [1:0]  line_state    = sse_pkg::PHASE_FIELD;
   logic [1:0]  name_kind     = sse_pkg::FIELD_NONE;
   logic [2:0]  name_matched  = '0;
   logic        value_begun   = 1'b0;
   logic        line_open     = 1'b0;
   logic        cr_pending    = 1'b0;
   logic        data_seen     = 1'b0;
   logic        name_seen     = 1'b0;
   logic [31:0] event_bytes   = '0;
   logic        overflow_flag = 1'b0;
   logic [31:0] event_limit   = sse_pkg::LIMIT_RESET;

   string data_field  = "data";
   string event_field = "event";
   string odd_fields [10] = '{"dat", "datax", "dta", "even", "events", "Data", "id",
                              "retry", "d", "eventevent"};

   sse_event_stream_parser DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #1 clock = ~clock;

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic void add_token(logic [2:0] kind, logic [7:0] value, logic sep,
                                     logic empty_name);
      sse_pkg::rsp_type t;
      t.kind           = kind;
      t.out_byte       = value;
      t.with_separator = sep;
      t.name_empty     = empty_name;
      t.last           = 1'b0;
      step_tokens.insert(step_tokens.size(), t);
   endfunction

   function automatic logic over_limit();
      return ({1'b0, event_bytes} + 33'd1) > {1'b0, event_limit};
   endfunction

   function automatic void reset_line();
      line_state   = sse_pkg::PHASE_FIELD;
      name_matched = '0;
      name_kind    = sse_pkg::FIELD_NONE;
      value_begun  = 1'b0;
      line_open    = 1'b0;
   endfunction

   // Dispatch: a done token only when the event carries data.
   function automatic void close_event();
      if (data_seen)
         add_token(sse_pkg::KIND_DONE, 8'h00, 1'b0, !name_seen);
      data_seen   = 1'b0;
      name_seen   = 1'b0;
      event_bytes = '0;
   endfunction

   // A bare "data" or "event" line raises its start token at the line end.
   function automatic void finish_line();
      if (line_state == sse_pkg::PHASE_FIELD) begin
         if (name_kind == sse_pkg::FIELD_DATA && name_matched == sse_pkg::DATA_LEN) begin
            add_token(sse_pkg::KIND_DATA_START, 8'h00, data_seen, 1'b0);
            data_seen = 1'b1;
         end else if (name_kind == sse_pkg::FIELD_EVENT &&
                      name_matched == sse_pkg::EVENT_LEN) begin
            add_token(sse_pkg::KIND_NAME_START, 8'h00, 1'b0, 1'b0);
            name_seen = 1'b0;
         end
      end
      reset_line();
   endfunction

   // One character of the field name, or the colon that ends it.
   function automatic void scan_name_char(logic [7:0] b);
      if (b == sse_pkg::CHAR_COLON) begin
         if (!line_open) begin
            line_state = sse_pkg::PHASE_COMMENT;
         end else begin
            if (name_kind == sse_pkg::FIELD_DATA &&
                name_matched == sse_pkg::DATA_LEN) begin
               add_token(sse_pkg::KIND_DATA_START, 8'h00, data_seen, 1'b0);
               data_seen = 1'b1;
            end else if (name_kind == sse_pkg::FIELD_EVENT &&
                         name_matched == sse_pkg::EVENT_LEN) begin
               add_token(sse_pkg::KIND_NAME_START, 8'h00, 1'b0, 1'b0);
               name_seen = 1'b0;
            end else begin
               name_kind = sse_pkg::FIELD_OTHER;
            end
            line_state = sse_pkg::PHASE_VALUE;
         end
      end else begin
         case (name_kind)
            sse_pkg::FIELD_NONE: begin
               if (b == data_field[0]) begin
                  name_kind    = sse_pkg::FIELD_DATA;
                  name_matched = 3'd1;
               end else if (b == event_field[0]) begin
                  name_kind    = sse_pkg::FIELD_EVENT;
                  name_matched = 3'd1;
               end else begin
                  name_kind = sse_pkg::FIELD_OTHER;
               end
            end
            sse_pkg::FIELD_DATA: begin
               if (name_matched < sse_pkg::DATA_LEN && b == data_field[name_matched])
                  name_matched++;
               else
                  name_kind = sse_pkg::FIELD_OTHER;
            end
            sse_pkg::FIELD_EVENT: begin
               if (name_matched < sse_pkg::EVENT_LEN && b == event_field[name_matched])
                  name_matched++;
               else
                  name_kind = sse_pkg::FIELD_OTHER;
            end
            default: ;
         endcase
      end
   endfunction

   // Work out the tokens one accepted word causes and queue them.
   function automatic void parse_word(sse_pkg::req_type w);
      sse_pkg::rsp_type t;
      step_tokens.delete();
      if (overflow_flag) begin
         add_token(sse_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b0);
      end else if (w.mode == sse_pkg::MODE_EOS) begin
         cr_pending = 1'b0;
         if (line_open && over_limit()) begin
            overflow_flag = 1'b1;
            add_token(sse_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b0);
         end else begin
            if (line_open)
               finish_line();
            reset_line();
            close_event();
         end
      end else if (cr_pending && w.byte_value == sse_pkg::CHAR_LF) begin
         // The LF of a CRLF pair is dropped and not charged.
         cr_pending = 1'b0;
      end else begin
         cr_pending = 1'b0;
         if (over_limit()) begin
            overflow_flag = 1'b1;
            add_token(sse_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b0);
         end else begin
            event_bytes++;
            if (w.byte_value == sse_pkg::CHAR_CR || w.byte_value == sse_pkg::CHAR_LF) begin
               cr_pending = (w.byte_value == sse_pkg::CHAR_CR);
               if (line_open)
                  finish_line();
               else
                  close_event();
            end else if (line_state == sse_pkg::PHASE_FIELD) begin
               scan_name_char(w.byte_value);
               line_open = 1'b1;
            end else if (line_state == sse_pkg::PHASE_VALUE) begin
               if (!value_begun && w.byte_value == sse_pkg::CHAR_SPACE) begin
                  value_begun = 1'b1;
               end else begin
                  value_begun = 1'b1;
                  if (name_kind == sse_pkg::FIELD_DATA) begin
                     add_token(sse_pkg::KIND_DATA_BYTE, w.byte_value, 1'b0, 1'b0);
                  end else if (name_kind == sse_pkg::FIELD_EVENT) begin
                     add_token(sse_pkg::KIND_NAME_BYTE, w.byte_value, 1'b0, 1'b0);
                     name_seen = 1'b1;
                  end
               end
            end
         end
      end
      if (step_tokens.size() != 0) begin
         t = step_tokens.pop_back();
         t.last = 1'b1;
         step_tokens.insert(step_tokens.size(), t);
      end
      foreach (step_tokens[i])
         expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
   endfunction

   function automatic void check_token(sse_pkg::rsp_type got);
      sse_pkg::rsp_type want;
      if (expected_tokens.size() == 0) begin
         $error("unexpected word: kind %0d, out_byte %0h", got.kind, got.out_byte);
         failures++;
         return;
      end
      want = expected_tokens.pop_front();
      if (got.kind !== want.kind) begin
         $error("kind: expected %0d, got %0d", want.kind, got.kind);
         failures++;
      end
      if (got.out_byte !== want.out_byte) begin
         $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
         failures++;
      end
      if (got.with_separator !== want.with_separator) begin
         $error("with_separator: expected %0b, got %0b", want.with_separator,
                got.with_separator);
         failures++;
      end
      if (got.name_empty !== want.name_empty) begin
         $error("name_empty: expected %0b, got %0b", want.name_empty, got.name_empty);
         failures++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0b, got %0b", want.last, got.last);
         failures++;
      end
   endfunction

   // Per-word pause, with occasional stretches where a side never pauses.
   function automatic int unsigned draw_pause(inout bit steady);
      if ($urandom_range(0, 31) == 0)
         steady = !steady;
      return steady ? 0 : $urandom_range(0, 4);
   endfunction

   // Driver: send queued words, holding each until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            parse_word(req_data);
            send_gap = draw_pause(send_steady);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_data  <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: take result words and compare them in order.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_token(rsp_data);
            take_gap = draw_pause(take_steady);
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic push_byte(logic [7:0] b);
      sse_pkg::req_type w;
      w.mode       = sse_pkg::MODE_BYTE;
      w.byte_value = b;
      pending_words.insert(pending_words.size(), w);
      words_queued++;
   endtask

   // The byte lane is don't-care at end of stream, so it carries noise.
   task automatic push_eos();
      sse_pkg::req_type w;
      w.mode       = sse_pkg::MODE_EOS;
      w.byte_value = 8'($urandom_range(0, 255));
      pending_words.insert(pending_words.size(), w);
      words_queued++;
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++)
         push_byte(s[i]);
   endtask

   // Any byte but a line terminator, biased toward spaces, colons and letters.
   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      case ($urandom_range(0, 7))
         0: b = sse_pkg::CHAR_SPACE;
         1: b = sse_pkg::CHAR_COLON;
         2: b = 8'($urandom_range(8'h61, 8'h7A));
         default: begin
            b = 8'($urandom_range(0, 255));
            if (b == sse_pkg::CHAR_LF || b == sse_pkg::CHAR_CR)
               b = 8'h78;
         end
      endcase
      return b;
   endfunction

   task automatic push_line_end();
      case ($urandom_range(0, 2))
         0: push_byte(sse_pkg::CHAR_LF);
         1: push_byte(sse_pkg::CHAR_CR);
         default: begin
            push_byte(sse_pkg::CHAR_CR);
            push_byte(sse_pkg::CHAR_LF);
         end
      endcase
   endtask

   // Field value with no, one or two leading spaces.
   task automatic push_value();
      repeat ($urandom_range(0, 2))
         push_byte(sse_pkg::CHAR_SPACE);
      repeat ($urandom_range(0, 8))
         push_byte(text_byte());
   endtask

   task automatic push_noise();
      logic [7:0] b;
      repeat ($urandom_range(1, 12)) begin
         case ($urandom_range(0, 5))
            0: b = sse_pkg::CHAR_LF;
            1: b = sse_pkg::CHAR_CR;
            2: b = sse_pkg::CHAR_COLON;
            default: b = 8'($urandom_range(0, 255));
         endcase
         push_byte(b);
      end
   endtask

   task automatic push_random_line();
      bit stream_closed;
      stream_closed = 1'b0;
      case ($urandom_range(0, 11))
         0, 1, 2, 3: begin
            push_text("data:");
            push_value();
         end
         4: push_text("data");
         5, 6: begin
            push_text("event:");
            push_value();
         end
         7: push_text("event");
         8: begin
            push_byte(sse_pkg::CHAR_COLON);
            push_value();
         end
         9: begin
            push_text(odd_fields[$urandom_range(0, 9)]);
            if ($urandom_range(0, 1) == 1) begin
               push_byte(sse_pkg::CHAR_COLON);
               push_value();
            end
         end
         10: begin
            // Stream cut off in the middle of a data line.
            push_text("data:");
            push_value();
            push_eos();
            stream_closed = 1'b1;
         end
         default: push_noise();
      endcase
      if (!stream_closed)
         push_line_end();
   endtask

   // Mostly well-formed events ended by a blank line or end of stream.
   task automatic push_random_event();
      if ($urandom_range(0, 9) == 0) begin
         push_noise();
      end else begin
         repeat ($urandom_range(0, 4))
            push_random_line();
         if ($urandom_range(0, 7) == 0)
            push_eos();
         else
            push_line_end();
      end
   endtask

   task automatic push_random_traffic(int unsigned count);
      int unsigned stop_at;
      stop_at = words_queued + count;
      while (words_queued < stop_at)
         push_random_event();
   endtask

   task automatic set_limit(logic [31:0] value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      event_limit = value;
      @(negedge clock);
   endtask

   // Wait until every word is sent and every token is back, then let the
   // pipeline settle in case the last words caused no tokens.
   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_tokens.size() != 0);
      repeat (DRAIN_CYCLES)
         @(negedge clock);
   endtask

   initial begin
      logic [31:0] tight_limit;

      repeat (2)
         @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: byte extremes, CRLF, a comment, a bare event line, a blank
      // line with an empty name, and end of stream closing a bare data line.
      push_text("data: ");
      push_byte(8'hFF);
      push_byte(8'h00);
      push_text("\r\n");
      push_text(":c\n");
      push_text("event\r");
      push_byte(sse_pkg::CHAR_CR);
      push_text("data");
      push_eos();
      wait_idle();

      // Bulk traffic with the widest limit.
      set_limit(WIDE_LIMIT);
      push_random_traffic(600);
      push_eos();
      wait_idle();

      // Events that fill the limit exactly; the LF of a CRLF is not charged.
      set_limit(FIT_LIMIT);
      push_text("data:abcde\n\n");
      push_text("data:abcde\r\n\r\n");
      wait_idle();

      // A zero limit still lets end of stream pass when no line is open.
      set_limit(ZERO_LIMIT);
      repeat (3)
         push_eos();
      wait_idle();

      set_limit(OPEN_LIMIT);
      push_random_traffic(550);
      push_eos();
      wait_idle();

      // Small limit: force the size error, then check that it stays raised.
      tight_limit = $urandom_range(8, 40);
      set_limit(tight_limit);
      if ($urandom_range(0, 1) == 1) begin
         push_text("data:");
         repeat (tight_limit - 5)
            push_byte(text_byte());
         push_eos();
      end else begin
         push_random_traffic(80);
         push_text("data:");
         repeat (64)
            push_byte(text_byte());
         push_line_end();
      end
      push_random_traffic(30);
      push_eos();
      wait_idle();

      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/sse_pkg.sv
rtl/sse_event_stream_parser.sv
rtl/sse_checker.sv
tb/sse_event_stream_parser_tb.sv
